[hdl/mvpm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvpm_pkg
// Shared command codes, voice modes and fixed constants of the pcm mixer.
// ----------------------------------------------------------------------------
package mvpm_pkg;

  localparam logic [2:0] CMD_LOAD    = 3'd0;
  localparam logic [2:0] CMD_PLAY    = 3'd1;
  localparam logic [2:0] CMD_SETMODE = 3'd2;
  localparam logic [2:0] CMD_SETVOL  = 3'd3;
  localparam logic [2:0] CMD_SETPOS  = 3'd4;
  localparam logic [2:0] CMD_STOP    = 3'd5;
  localparam logic [2:0] CMD_QUERY   = 3'd6;
  localparam logic [2:0] CMD_RENDER  = 3'd7;

  localparam logic [1:0] MODE_OFF  = 2'd0;
  localparam logic [1:0] MODE_ONCE = 2'd1;
  localparam logic [1:0] MODE_LOOP = 2'd2;
  localparam logic [1:0] MODE_ALT  = 2'd3;

  localparam logic [15:0] MASTER_RESET   = 16'h0080;
  localparam logic [12:0] MAX_CLIP_WORDS = 13'd4096;

  typedef logic signed [15:0] gain_t;

endpackage

[hdl/multi_voice_pcm_mixer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_voice_pcm_mixer
// Multi-voice 8-bit pcm mixer: sample memory, voice table, banked render.
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  in_      start / busy         cmd, slot, address, length_words, position,
//                                sample_word, mode, volume, keep_reserved, clip_id
//  out_     out_valid strobe     mixed_samples, last, slot_found, slot_index,
//                                is_playing
//  cfg_     cfg_valid/cfg_ready  cfg_data (master volume)
//
//  every command other than render is captured at start, runs in S_EXEC and gives its one registered result.
//  render: S_CLEAR clears the accumulator, then per active voice each word gets
//  an end check/read, then 4 x multiply and accumulate on the shared multiplier;
//  then each output sample is read, scaled by the master volume and packed.
//  busy stays high until the last result; results cannot be stalled.
//  synchronous reset clears the voice table and sets master volume to 128.
//  the user keeps SAMPLE_WORDS a power of two, the block does not enforce it; addresses wrap modulo it.
module multi_voice_pcm_mixer #(
  parameter int VOICES       = 8,
  parameter int SAMPLE_WORDS = 4096,
  parameter int BANK_SAMPLES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_cmd,
  input  logic [2:0]  in_slot,
  input  logic [11:0] in_address,
  input  logic [12:0] in_length_words,
  input  logic [11:0] in_position,
  input  logic [31:0] in_sample_word,
  input  logic [1:0]  in_mode,
  input  logic signed [15:0] in_volume,
  input  logic        in_keep_reserved,
  input  logic [7:0]  in_clip_id,
  output logic        out_valid,
  output logic [31:0] out_mixed_samples,
  output logic        out_last,
  output logic        out_slot_found,
  output logic [2:0]  out_slot_index,
  output logic        out_is_playing,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic signed [15:0] cfg_data
);

  localparam int VIW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int VCW = $clog2(VOICES + 1);
  localparam int MAW = (SAMPLE_WORDS > 1) ? $clog2(SAMPLE_WORDS) : 1;
  localparam int AAW = $clog2(BANK_SAMPLES);
  localparam logic [AAW-1:0] N_LAST = AAW'(BANK_SAMPLES - 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EXEC  = 4'd1;
  localparam logic [3:0] S_CLEAR = 4'd2;
  localparam logic [3:0] S_VCHK  = 4'd3;
  localparam logic [3:0] S_WCHK  = 4'd4;
  localparam logic [3:0] S_MUL   = 4'd5;
  localparam logic [3:0] S_ACC   = 4'd6;
  localparam logic [3:0] S_OREAD = 4'd7;
  localparam logic [3:0] S_OMUL  = 4'd8;
  localparam logic [3:0] S_OPACK = 4'd9;

  logic [3:0]  state_r;
  logic [2:0]  cmd_r, slot_r;
  logic [11:0] addr_r, pos_r;
  logic [12:0] len_r;
  logic [31:0] sword_r;
  logic [1:0]  mode_r;
  logic [15:0] vol_r;
  logic        keep_r;
  logic [7:0]  clip_r;
  logic signed [15:0] master_r;

  logic [1:0]  vmode_r  [VOICES];
  logic        vres_r   [VOICES];
  logic [7:0]  vclip_r  [VOICES];
  logic [11:0] vstart_r [VOICES];
  logic [12:0] vend_r   [VOICES];
  logic [12:0] vcur_r   [VOICES];
  logic [15:0] vgain_r  [VOICES];

  logic [VCW-1:0] v_r;
  logic [AAW-1:0] n_r;
  logic [31:0]    pack_r;

  logic        ov_r, olast_r, ofound_r, oplay_r;
  logic [31:0] omix_r;
  logic [2:0]  oidx_r;

  logic [VIW-1:0] vi, si;
  logic           slot_ok;
  logic           free_found;
  logic [VIW-1:0] free_idx;
  logic [1:0]     mode_norm;
  logic [12:0]    len_sat;

  logic           s_re, s_we;
  logic [MAW-1:0] s_raddr, s_waddr;
  logic [31:0]    s_rdata;
  logic           a_re, a_we;
  logic [AAW-1:0] a_waddr;
  logic [15:0]    a_wdata, a_rdata;
  logic           m_en;
  mvpm_pkg::gain_t m_a, m_b;
  logic signed [31:0] m_p;
  logic [7:0]     sbyte;
  logic           at_end;
  logic [31:0]    pack_nxt;

  assign vi = v_r[VIW-1:0];
  assign si = VIW'(slot_r);
  assign slot_ok = (32'(slot_r) < VOICES);
  assign mode_norm = (mode_r == mvpm_pkg::MODE_ALT) ? mvpm_pkg::MODE_LOOP : mode_r;
  assign len_sat = (len_r > mvpm_pkg::MAX_CLIP_WORDS) ? mvpm_pkg::MAX_CLIP_WORDS : len_r;
  assign at_end = (vcur_r[vi] >= vend_r[vi]);

  // first slot that is neither reserved nor playing
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = VOICES - 1; i >= 0; i--) begin
      if (!vres_r[i] && vmode_r[i] == mvpm_pkg::MODE_OFF) begin
        free_found = 1'b1;
        free_idx   = VIW'(i);
      end
    end
  end

  always_comb begin
    case (n_r[1:0])
      2'd0:    sbyte = s_rdata[7:0];
      2'd1:    sbyte = s_rdata[15:8];
      2'd2:    sbyte = s_rdata[23:16];
      default: sbyte = s_rdata[31:24];
    endcase
  end

  always_comb begin
    pack_nxt = pack_r;
    case (n_r[1:0])
      2'd0:    pack_nxt[7:0]   = m_p[15:8];
      2'd1:    pack_nxt[15:8]  = m_p[15:8];
      2'd2:    pack_nxt[23:16] = m_p[15:8];
      default: pack_nxt[31:24] = m_p[15:8];
    endcase
  end

  assign s_we    = (state_r == S_EXEC) && (cmd_r == mvpm_pkg::CMD_LOAD);
  assign s_waddr = MAW'(addr_r);
  assign s_re    = (state_r == S_WCHK);
  assign s_raddr = at_end ? MAW'(vstart_r[vi]) : MAW'(vcur_r[vi]);

  assign a_re    = (state_r == S_MUL) || (state_r == S_OREAD);
  assign a_we    = (state_r == S_CLEAR) || (state_r == S_ACC);
  assign a_waddr = n_r;
  assign a_wdata = (state_r == S_CLEAR) ? 16'd0 : (a_rdata + m_p[23:8]);

  assign m_en = (state_r == S_MUL) || (state_r == S_OMUL);
  assign m_a  = (state_r == S_MUL) ? {{8{sbyte[7]}}, sbyte} : a_rdata;
  assign m_b  = (state_r == S_MUL) ? vgain_r[vi] : master_r;

  mvpm_sample_ram #(.DEPTH(SAMPLE_WORDS), .AW(MAW)) u_sram (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(sword_r),
    .re(s_re), .raddr(s_raddr), .rdata(s_rdata)
  );

  mvpm_acc_ram #(.DEPTH(BANK_SAMPLES), .AW(AAW)) u_aram (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
    .re(a_re), .raddr(n_r), .rdata(a_rdata)
  );

  mvpm_mul u_mul (
    .clk(clk), .en(m_en), .op_a(m_a), .op_b(m_b), .prod(m_p)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      master_r <= mvpm_pkg::MASTER_RESET;
      ov_r     <= 1'b0;
      v_r      <= '0;
      n_r      <= '0;
      for (int i = 0; i < VOICES; i++) begin
        vmode_r[i]  <= mvpm_pkg::MODE_OFF;
        vres_r[i]   <= 1'b0;
        vclip_r[i]  <= '0;
        vstart_r[i] <= '0;
        vend_r[i]   <= '0;
        vcur_r[i]   <= '0;
        vgain_r[i]  <= '0;
      end
    end else begin
      ov_r <= 1'b0;
      if (cfg_valid) begin
        master_r <= cfg_data;
      end
      case (state_r)
        S_IDLE: begin
          if (start) begin
            cmd_r   <= in_cmd;
            slot_r  <= in_slot;
            addr_r  <= in_address;
            len_r   <= in_length_words;
            pos_r   <= in_position;
            sword_r <= in_sample_word;
            mode_r  <= in_mode;
            vol_r   <= in_volume;
            keep_r  <= in_keep_reserved;
            clip_r  <= in_clip_id;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          omix_r   <= '0;
          olast_r  <= 1'b1;
          ofound_r <= 1'b0;
          oidx_r   <= '0;
          oplay_r  <= 1'b0;
          ov_r     <= 1'b1;
          state_r  <= S_IDLE;
          case (cmd_r)
            mvpm_pkg::CMD_PLAY: begin
              if (free_found) begin
                vmode_r[free_idx]  <= mode_norm;
                vclip_r[free_idx]  <= clip_r;
                vres_r[free_idx]   <= keep_r;
                vgain_r[free_idx]  <= vol_r;
                vstart_r[free_idx] <= addr_r;
                vend_r[free_idx]   <= {1'b0, addr_r} + len_sat;
                vcur_r[free_idx]   <= {1'b0, addr_r};
                ofound_r <= 1'b1;
                oidx_r   <= 3'(free_idx);
              end
            end
            mvpm_pkg::CMD_SETMODE: begin
              if (slot_ok) vmode_r[si] <= mode_norm;
            end
            mvpm_pkg::CMD_SETVOL: begin
              if (slot_ok) vgain_r[si] <= vol_r;
            end
            mvpm_pkg::CMD_SETPOS: begin
              if (slot_ok) vcur_r[si] <= {1'b0, vstart_r[si]} + {1'b0, pos_r};
            end
            mvpm_pkg::CMD_STOP: begin
              if (slot_ok) begin
                vmode_r[si] <= mvpm_pkg::MODE_OFF;
                vres_r[si]  <= 1'b0;
              end
            end
            mvpm_pkg::CMD_QUERY: begin
              oplay_r <= slot_ok && (vclip_r[si] == clip_r) &&
                         (vmode_r[si] != mvpm_pkg::MODE_OFF);
            end
            mvpm_pkg::CMD_RENDER: begin
              ov_r    <= 1'b0;
              n_r     <= '0;
              state_r <= S_CLEAR;
            end
            default: begin
              // load word: memory write happens in this cycle
            end
          endcase
        end
        S_CLEAR: begin
          if (n_r == N_LAST) begin
            n_r     <= '0;
            v_r     <= '0;
            state_r <= S_VCHK;
          end else begin
            n_r <= n_r + 1'b1;
          end
        end
        S_VCHK: begin
          n_r <= '0;
          if (32'(v_r) == VOICES) begin
            state_r <= S_OREAD;
          end else if (vmode_r[vi] == mvpm_pkg::MODE_OFF) begin
            v_r <= v_r + 1'b1;
          end else begin
            state_r <= S_WCHK;
          end
        end
        S_WCHK: begin
          if (at_end) begin
            vcur_r[vi] <= {1'b0, vstart_r[vi]};
            if (vmode_r[vi] == mvpm_pkg::MODE_ONCE) begin
              // once voice ends: skip the rest of this bank
              vmode_r[vi] <= mvpm_pkg::MODE_OFF;
              v_r         <= v_r + 1'b1;
              state_r     <= S_VCHK;
            end else begin
              state_r <= S_MUL;
            end
          end else begin
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          state_r <= S_ACC;
        end
        S_ACC: begin
          if (n_r[1:0] == 2'd3) begin
            vcur_r[vi] <= vcur_r[vi] + 13'd1;
            if (n_r == N_LAST) begin
              n_r     <= '0;
              v_r     <= v_r + 1'b1;
              state_r <= S_VCHK;
            end else begin
              n_r     <= n_r + 1'b1;
              state_r <= S_WCHK;
            end
          end else begin
            n_r     <= n_r + 1'b1;
            state_r <= S_MUL;
          end
        end
        S_OREAD: begin
          state_r <= S_OMUL;
        end
        S_OMUL: begin
          state_r <= S_OPACK;
        end
        S_OPACK: begin
          pack_r  <= pack_nxt;
          state_r <= S_OREAD;
          n_r     <= n_r + 1'b1;
          if (n_r[1:0] == 2'd3) begin
            ov_r     <= 1'b1;
            omix_r   <= pack_nxt;
            olast_r  <= (n_r == N_LAST);
            ofound_r <= 1'b0;
            oidx_r   <= '0;
            oplay_r  <= 1'b0;
            if (n_r == N_LAST) begin
              n_r     <= '0;
              state_r <= S_IDLE;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy              = (state_r != S_IDLE);
  assign cfg_ready         = 1'b1;
  assign out_valid         = ov_r;
  assign out_mixed_samples = omix_r;
  assign out_last          = olast_r;
  assign out_slot_found    = ofound_r;
  assign out_slot_index    = oidx_r;
  assign out_is_playing    = oplay_r;

endmodule

[hdl/mvpm_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvpm_mul
// Shared signed 16x16 multiplier with a registered product.
// ----------------------------------------------------------------------------
module mvpm_mul (
  input  logic                clk,
  input  logic                en,
  input  mvpm_pkg::gain_t     op_a,
  input  mvpm_pkg::gain_t     op_b,
  output logic signed [31:0]  prod
);

  logic signed [31:0] prod_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= op_a * op_b;
    end
  end

  assign prod = prod_r;

endmodule

[hdl/mvpm_sample_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvpm_sample_ram
// Sample word memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
module mvpm_sample_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hdl/mvpm_acc_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvpm_acc_ram
// Mix accumulator memory, 16-bit words, registered read.
// ----------------------------------------------------------------------------
module mvpm_acc_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [15:0]   rdata
);

  logic [15:0] mem [DEPTH];
  logic [15:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[sim/tb_multi_voice_pcm_mixer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multi_voice_pcm_mixer
// Self-checking bench for the pcm mixer. A behavioral copy of the voice table,
// the sample memory and the render path predicts every result. Directed
// commands cover the corner cases, then random command streams run under
// several sender idle rates and master volume settings.
// ----------------------------------------------------------------------------
module tb_multi_voice_pcm_mixer;

  localparam int NV = 8;
  localparam int MEM_WORDS = 4096;
  localparam int BANK = 256;
  localparam int BANK_WORDS = BANK / 4;
  localparam int POOL = 16;
  localparam int STALL_LIMIT = 50000;

  typedef struct {
    logic [2:0]  cmd;
    logic [2:0]  slot;
    logic [11:0] address;
    logic [12:0] length_words;
    logic [11:0] position;
    logic [31:0] sample_word;
    logic [1:0]  mode;
    logic [15:0] volume;
    logic        keep;
    logic [7:0]  clip;
  } mixer_cmd_t;

  typedef struct {
    logic [31:0] mixed;
    logic        last;
    logic        found;
    logic [2:0]  index;
    logic        playing;
  } mixer_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0]  in_cmd = '0;
  logic [2:0]  in_slot = '0;
  logic [11:0] in_address = '0;
  logic [12:0] in_length_words = '0;
  logic [11:0] in_position = '0;
  logic [31:0] in_sample_word = '0;
  logic [1:0]  in_mode = '0;
  logic signed [15:0] in_volume = '0;
  logic        in_keep_reserved = 1'b0;
  logic [7:0]  in_clip_id = '0;
  logic        out_valid;
  logic [31:0] out_mixed_samples;
  logic        out_last;
  logic        out_slot_found;
  logic [2:0]  out_slot_index;
  logic        out_is_playing;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic signed [15:0] cfg_data = '0;

  multi_voice_pcm_mixer uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_slot(in_slot), .in_address(in_address),
    .in_length_words(in_length_words), .in_position(in_position),
    .in_sample_word(in_sample_word), .in_mode(in_mode), .in_volume(in_volume),
    .in_keep_reserved(in_keep_reserved), .in_clip_id(in_clip_id),
    .out_valid(out_valid), .out_mixed_samples(out_mixed_samples),
    .out_last(out_last), .out_slot_found(out_slot_found),
    .out_slot_index(out_slot_index), .out_is_playing(out_is_playing),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // predicted mixer state
  logic [1:0]  v_mode [NV];
  logic        v_reserved [NV];
  logic [7:0]  v_clip [NV];
  logic [12:0] v_start [NV];
  logic [12:0] v_end [NV];
  logic [12:0] v_cursor [NV];
  logic signed [15:0] v_gain [NV];
  logic [31:0] sample_mem [MEM_WORDS];
  bit          loaded [MEM_WORDS];
  logic signed [15:0] master_gain;

  mixer_result_t pending_results [$];
  int failures = 0;
  int commands_sent = 0;
  int results_seen = 0;
  int renders_sent = 0;
  int gap_pct = 0;
  int quiet_cycles = 0;

  function automatic mixer_cmd_t blank_cmd(logic [2:0] cmd);
    mixer_cmd_t c;
    c = '{default: '0};
    c.cmd = cmd;
    return c;
  endfunction

  function automatic logic [1:0] fold_mode(logic [1:0] m);
    return (m == mvpm_pkg::MODE_ALT) ? mvpm_pkg::MODE_LOOP : m;
  endfunction

  // true when every word the voice can reach has been loaded
  function automatic bit clip_loaded(int v);
    int last_w;
    last_w = (v_end[v] > v_start[v]) ? int'(v_end[v]) : int'(v_start[v]) + 1;
    for (int w = int'(v_start[v]); w < last_w; w++) begin
      if (!loaded[w % MEM_WORDS]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void render_bank();
    logic [15:0] acc [BANK];
    logic [31:0] word;
    logic signed [7:0] s;
    logic signed [15:0] a;
    logic signed [31:0] p;
    mixer_result_t r;
    bit done;
    int n;
    for (int i = 0; i < BANK; i++) acc[i] = '0;
    for (int v = 0; v < NV; v++) begin
      if (v_mode[v] != mvpm_pkg::MODE_OFF) begin
        n = 0;
        done = 1'b0;
        for (int w = 0; w < BANK_WORDS && !done; w++) begin
          if (v_cursor[v] >= v_end[v]) begin
            v_cursor[v] = v_start[v];
            // a play-once voice ends here and adds nothing more to this bank
            if (v_mode[v] == mvpm_pkg::MODE_ONCE) begin
              v_mode[v] = mvpm_pkg::MODE_OFF;
              done = 1'b1;
            end
          end
          if (!done) begin
            word = sample_mem[v_cursor[v][11:0]];
            for (int k = 0; k < 4; k++) begin
              s = word[8*k +: 8];
              p = s * v_gain[v];
              acc[n] = acc[n] + p[23:8];
              n++;
            end
            v_cursor[v] = v_cursor[v] + 13'd1;
          end
        end
      end
    end
    for (int w = 0; w < BANK_WORDS; w++) begin
      r = '{default: '0};
      for (int k = 0; k < 4; k++) begin
        a = acc[4*w + k];
        p = a * master_gain;
        r.mixed[8*k +: 8] = p[15:8];
      end
      r.last = (w == BANK_WORDS - 1);
      pending_results.push_back(r);
    end
  endfunction

  function automatic void predict_command(mixer_cmd_t c);
    mixer_result_t r;
    int v;
    r = '{default: '0};
    r.last = 1'b1;
    case (c.cmd)
      mvpm_pkg::CMD_LOAD: begin
        sample_mem[c.address] = c.sample_word;
        loaded[c.address] = 1'b1;
      end
      mvpm_pkg::CMD_PLAY: begin
        v = 0;
        while (v < NV && (v_reserved[v] || v_mode[v] != mvpm_pkg::MODE_OFF)) v++;
        if (v < NV) begin
          v_mode[v] = fold_mode(c.mode);
          v_clip[v] = c.clip;
          v_reserved[v] = c.keep;
          v_gain[v] = c.volume;
          v_start[v] = {1'b0, c.address};
          v_end[v] = {1'b0, c.address} +
                     ((c.length_words > mvpm_pkg::MAX_CLIP_WORDS) ?
                      mvpm_pkg::MAX_CLIP_WORDS : c.length_words);
          v_cursor[v] = {1'b0, c.address};
          r.found = 1'b1;
          r.index = v[2:0];
        end
      end
      mvpm_pkg::CMD_SETMODE: v_mode[c.slot] = fold_mode(c.mode);
      mvpm_pkg::CMD_SETVOL: v_gain[c.slot] = c.volume;
      mvpm_pkg::CMD_SETPOS: v_cursor[c.slot] = v_start[c.slot] + {1'b0, c.position};
      mvpm_pkg::CMD_STOP: begin
        v_mode[c.slot] = mvpm_pkg::MODE_OFF;
        v_reserved[c.slot] = 1'b0;
      end
      mvpm_pkg::CMD_QUERY: r.playing = (v_clip[c.slot] == c.clip) &&
                                      (v_mode[c.slot] != mvpm_pkg::MODE_OFF);
      default: begin
        render_bank();
        renders_sent++;
      end
    endcase
    if (c.cmd != mvpm_pkg::CMD_RENDER) pending_results.push_back(r);
  endfunction

  // drives one command, holds it until the mixer takes it, then maybe idles
  task automatic send_command(mixer_cmd_t c);
    start <= 1'b1;
    in_cmd <= c.cmd;
    in_slot <= c.slot;
    in_address <= c.address;
    in_length_words <= c.length_words;
    in_position <= c.position;
    in_sample_word <= c.sample_word;
    in_mode <= c.mode;
    in_volume <= c.volume;
    in_keep_reserved <= c.keep;
    in_clip_id <= c.clip;
    do @(posedge clk); while (busy);
    predict_command(c);
    commands_sent++;
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic write_master(logic signed [15:0] gain);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data <= gain;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    master_gain = gain;
  endtask

  task automatic play(logic [11:0] addr, logic [12:0] len, logic [1:0] mode,
                      logic [15:0] vol, logic keep, logic [7:0] clip);
    mixer_cmd_t c;
    c = blank_cmd(mvpm_pkg::CMD_PLAY);
    c.address = addr;
    c.length_words = len;
    c.mode = mode;
    c.volume = vol;
    c.keep = keep;
    c.clip = clip;
    send_command(c);
  endtask

  task automatic slot_cmd(logic [2:0] cmd, logic [2:0] slot, logic [1:0] mode,
                          logic [15:0] vol, logic [11:0] pos, logic [7:0] clip);
    mixer_cmd_t c;
    c = blank_cmd(cmd);
    c.slot = slot;
    c.mode = mode;
    c.volume = vol;
    c.position = pos;
    c.clip = clip;
    send_command(c);
  endtask

  task automatic load_word(logic [11:0] addr, logic [31:0] data);
    mixer_cmd_t c;
    c = blank_cmd(mvpm_pkg::CMD_LOAD);
    c.address = addr;
    c.sample_word = data;
    send_command(c);
  endtask

  task automatic test_preload();
    for (int a = 0; a < POOL; a++) load_word(a[11:0], $urandom());
    load_word(12'd4095, 32'h7F80_01FF);
  endtask

  task automatic test_directed();
    load_word(12'd1, 32'h8080_8080);
    load_word(12'd2, 32'h7F7F_7F7F);
    play(12'd0, 13'd4, mvpm_pkg::MODE_ALT, 16'h7FFF, 1'b1, 8'd5);
    play(12'd4095, 13'd1, mvpm_pkg::MODE_ONCE, 16'h8000, 1'b0, 8'd255);
    play(12'd8, 13'd0, mvpm_pkg::MODE_ONCE, 16'd256, 1'b0, 8'd1);
    play(12'd9, 13'd0, mvpm_pkg::MODE_LOOP, -16'sd256, 1'b0, 8'd2);
    slot_cmd(mvpm_pkg::CMD_QUERY, 3'd0, mvpm_pkg::MODE_OFF, '0, '0, 8'd5);
    slot_cmd(mvpm_pkg::CMD_QUERY, 3'd0, mvpm_pkg::MODE_OFF, '0, '0, 8'd4);
    slot_cmd(mvpm_pkg::CMD_QUERY, 3'd7, mvpm_pkg::MODE_OFF, '0, '0, 8'd0);
    slot_cmd(mvpm_pkg::CMD_RENDER, 3'd0, mvpm_pkg::MODE_OFF, '0, '0, 8'd0);
    slot_cmd(mvpm_pkg::CMD_SETVOL, 3'd1, mvpm_pkg::MODE_OFF, 16'h0100, '0, 8'd0);
    slot_cmd(mvpm_pkg::CMD_SETPOS, 3'd0, mvpm_pkg::MODE_OFF, '0, 12'd4095, 8'd0);
    slot_cmd(mvpm_pkg::CMD_SETMODE, 3'd1, mvpm_pkg::MODE_ALT, '0, '0, 8'd0);
    slot_cmd(mvpm_pkg::CMD_RENDER, 3'd0, mvpm_pkg::MODE_OFF, '0, '0, 8'd0);
    slot_cmd(mvpm_pkg::CMD_SETPOS, 3'd0, mvpm_pkg::MODE_OFF, '0, 12'd2, 8'd0);
    // fill every slot; the last three of these plays find no free slot
    for (int i = 0; i < NV; i++) begin
      play(12'd12, 13'd2, mvpm_pkg::MODE_LOOP, 16'h0040, 1'b1, 8'd9);
    end
    slot_cmd(mvpm_pkg::CMD_STOP, 3'd3, mvpm_pkg::MODE_OFF, '0, '0, 8'd0);
    // clip longer than memory saturates; stopped before any render reads it
    play(12'd0, 13'd8191, mvpm_pkg::MODE_ONCE, 16'h0100, 1'b0, 8'd77);
    slot_cmd(mvpm_pkg::CMD_QUERY, 3'd3, mvpm_pkg::MODE_OFF, '0, '0, 8'd77);
    slot_cmd(mvpm_pkg::CMD_STOP, 3'd3, mvpm_pkg::MODE_OFF, '0, '0, 8'd0);
    drain_results();
    slot_cmd(mvpm_pkg::CMD_RENDER, 3'd0, mvpm_pkg::MODE_OFF, '0, '0, 8'd0);
  endtask

  task automatic test_random(int count);
    mixer_cmd_t c;
    int pick;
    int a;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      c = blank_cmd(mvpm_pkg::CMD_QUERY);
      c.slot = 3'($urandom_range(NV - 1));
      c.mode = 2'($urandom_range(3));
      c.volume = 16'($urandom());
      c.position = 12'($urandom());
      c.clip = ($urandom_range(1) != 0) ? v_clip[c.slot] : 8'($urandom());
      if (pick < 15) begin
        c.cmd = mvpm_pkg::CMD_LOAD;
        c.address = ($urandom_range(1) != 0) ? 12'($urandom_range(POOL - 1)) :
                                               12'($urandom());
        c.sample_word = $urandom();
      end else if (pick < 35) begin
        c.cmd = mvpm_pkg::CMD_PLAY;
        a = $urandom_range(POOL - 1);
        c.address = 12'(a);
        c.length_words = 13'($urandom_range(POOL - a));
        c.keep = 1'($urandom_range(1));
      end else if (pick < 45) begin
        c.cmd = mvpm_pkg::CMD_SETMODE;
      end else if (pick < 55) begin
        c.cmd = mvpm_pkg::CMD_SETVOL;
      end else if (pick < 65) begin
        c.cmd = mvpm_pkg::CMD_SETPOS;
      end else if (pick < 77) begin
        c.cmd = mvpm_pkg::CMD_STOP;
      end else if (pick < 90) begin
        c.cmd = mvpm_pkg::CMD_QUERY;
      end else begin
        c.cmd = mvpm_pkg::CMD_RENDER;
      end
      // never wake a voice whose clip reaches memory that was never loaded
      if (c.cmd == mvpm_pkg::CMD_SETMODE && c.mode != mvpm_pkg::MODE_OFF &&
          !clip_loaded(c.slot))
        c.cmd = mvpm_pkg::CMD_STOP;
      send_command(c);
    end
  endtask

  always @(posedge clk) begin
    mixer_result_t e;
    if (rst_n && out_valid) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: mixed_samples %h", out_mixed_samples);
        failures++;
      end else begin
        e = pending_results.pop_front();
        if (out_mixed_samples !== e.mixed) begin
          $error("mixed_samples expected %h got %h", e.mixed, out_mixed_samples);
          failures++;
        end
        if (out_last !== e.last) begin
          $error("last expected %0d got %0d", e.last, out_last);
          failures++;
        end
        if (out_slot_found !== e.found) begin
          $error("slot_found expected %0d got %0d", e.found, out_slot_found);
          failures++;
        end
        if (out_slot_index !== e.index) begin
          $error("slot_index expected %0d got %0d", e.index, out_slot_index);
          failures++;
        end
        if (out_is_playing !== e.playing) begin
          $error("is_playing expected %0d got %0d", e.playing, out_is_playing);
          failures++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction at all
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int v = 0; v < NV; v++) begin
      v_mode[v] = mvpm_pkg::MODE_OFF;
      v_reserved[v] = 1'b0;
      v_clip[v] = '0;
      v_start[v] = '0;
      v_end[v] = '0;
      v_cursor[v] = '0;
      v_gain[v] = '0;
    end
    for (int a = 0; a < MEM_WORDS; a++) begin
      sample_mem[a] = '0;
      loaded[a] = 1'b0;
    end
    master_gain = mvpm_pkg::MASTER_RESET;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_preload();
    test_directed();
    gap_pct = 0;
    test_random(50);
    write_master(-16'sd32768);
    gap_pct = 60;
    test_random(50);
    write_master(16'sd32767);
    gap_pct = 12;
    test_random(45);
    write_master(16'sd0);
    test_random(20);
    write_master(16'sd256);
    gap_pct = 0;
    test_random(50);

    drain_results();
    repeat (20) @(posedge clk);
    $display("tb: %0d commands incl. %0d renders, %0d results checked", commands_sent,
             renders_sent, results_seen);
    $display("tb: directed corners, random streams at three idle rates, five master gains");
    if (failures == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
